[rtl/core/lqs_pkg.sv]
`default_nettype none

package lqs_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam int FIELD_BITS = 32;
    localparam int MODE_BITS  = 2;
    localparam int STAT_BITS  = 2;
    localparam int POS_BITS   = 4;
    localparam int COUNT_BITS = 5;

    typedef enum logic [MODE_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_APPEND = 2'd1,
        OP_DROP   = 2'd2,
        OP_SEARCH = 2'd3
    } t_lqs_op;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_lqs_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_READ,
        S_DONE
    } t_lqs_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic read_fb;
        logic capture;
    } t_lqs_cmd;

    typedef struct packed {
        t_lqs_op mode;
        logic    scan_end;
        logic    out_free;
    } t_lqs_stat;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

endpackage

`default_nettype wire

[rtl/core/list_queue_with_search.sv]
// Bounded list of signed values held in a ring, with front insert, back append,
// front drop and a front-to-back search for the first equal value.
// Input channel: i_in_valid with o_in_stall carries i_mode and i_value; an item is
// taken at a rising edge where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid with i_out_stall carries one result per item:
// o_status, o_found, o_position, o_count, o_front_value and o_back_value.
// Insert, append and drop are loaded, executed and have their front and back entries
// read before the result is captured. A search walks the held entries through one
// memory read port, one entry per cycle, comparing up to the count held and stopping
// early when a match is found.
// The block works on one item at a time, so it takes no new item before the result
// of the last one is captured. It accepts the next item as soon as the
// previous result has moved into the output register, so one result may wait
// there while the next item is in progress.
// When the receiver stalls, the result holds steady on the outputs, and a second
// finished result waits inside until the output register is freed.
// Reset (synchronous, active low) empties the list and drops any pending result;
// the entry memory itself is not cleared, as only held entries are ever read.
`default_nettype none

module list_queue_with_search (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [lqs_pkg::MODE_BITS-1:0]         i_mode,
    input  wire logic signed [lqs_pkg::FIELD_BITS-1:0] i_value,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [lqs_pkg::STAT_BITS-1:0]              o_status,
    output logic                                       o_found,
    output logic [lqs_pkg::POS_BITS-1:0]               o_position,
    output logic [lqs_pkg::COUNT_BITS-1:0]             o_count,
    output logic signed [lqs_pkg::FIELD_BITS-1:0]      o_front_value,
    output logic signed [lqs_pkg::FIELD_BITS-1:0]      o_back_value
);
    import lqs_pkg::*;

    t_lqs_cmd  cmd;
    t_lqs_stat stat;

    lqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lqs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_out_stall   (i_out_stall),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_count       (o_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count <= COUNT_BITS'(DEPTH)))
        else $error("Reported count exceeds the list depth.");

    a_found_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == STAT_DONE && o_position < o_count))
        else $error("A match was reported outside the held entries.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_FULL) |-> (o_count == COUNT_BITS'(DEPTH)))
        else $error("Insert refused although the list was not full.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("A new item was taken while the previous one was in progress.");

    a_capture_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> stat.out_free)
        else $error("Result captured over one still waiting to be taken.");

endmodule

`default_nettype wire

[rtl/core/lqs_ctrl.sv]
`default_nettype none

module lqs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire lqs_pkg::t_lqs_stat i_stat,
    output lqs_pkg::t_lqs_cmd      o_cmd,
    output logic                   o_in_stall
);
    import lqs_pkg::*;

    t_lqs_state r_state;
    t_lqs_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.mode == OP_SEARCH) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec       = 1'b1;
                o_cmd.scan_start = (i_stat.mode == OP_SEARCH);
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            S_READ: begin
                o_cmd.read_fb = 1'b1;
            end
            S_DONE: begin
                o_cmd.capture = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/lqs_dp.sv]
`default_nettype none

module lqs_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire lqs_pkg::t_lqs_cmd                    i_cmd,
    input  wire logic [lqs_pkg::MODE_BITS-1:0]        i_mode,
    input  wire logic signed [lqs_pkg::FIELD_BITS-1:0] i_value,
    input  wire logic                                 i_out_stall,
    output lqs_pkg::t_lqs_stat                        o_stat,
    output logic                                      o_out_valid,
    output logic [lqs_pkg::STAT_BITS-1:0]             o_status,
    output logic                                      o_found,
    output logic [lqs_pkg::POS_BITS-1:0]              o_position,
    output logic [lqs_pkg::COUNT_BITS-1:0]            o_count,
    output logic signed [lqs_pkg::FIELD_BITS-1:0]     o_front_value,
    output logic signed [lqs_pkg::FIELD_BITS-1:0]     o_back_value
);
    import lqs_pkg::*;

    logic [VALUE_BITS-1:0] mem [DEPTH];

    t_lqs_op               r_mode;
    logic [VALUE_BITS-1:0] r_value;
    logic [IDX_W-1:0]      r_front;
    logic [CNT_W-1:0]      r_count;
    t_lqs_status           r_status;
    logic                  r_found;
    logic [IDX_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_scan_idx;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_cmp_vld;
    logic [VALUE_BITS-1:0] r_rd_a;
    logic [VALUE_BITS-1:0] r_rd_b;

    logic                  r_out_valid;
    t_lqs_status           r_out_status;
    logic                  r_out_found;
    logic [POS_BITS-1:0]   r_out_pos;
    logic [COUNT_BITS-1:0] r_out_count;
    logic [FIELD_BITS-1:0] r_out_front;
    logic [FIELD_BITS-1:0] r_out_back;

    logic             full;
    logic             empty;
    logic [IDX_W-1:0] front_dec;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             scan_issue;
    logic             rd_en_a;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] back_addr;
    logic [IDX_W-1:0] last_idx;
    logic             hit;
    logic             out_free;

    always_comb begin
        full       = (r_count == CNT_W'(DEPTH));
        empty      = (r_count == '0);
        front_dec  = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - IDX_W'(1);
        wr_en      = i_cmd.exec && !full && (r_mode == OP_INSERT || r_mode == OP_APPEND);
        wr_addr    = (r_mode == OP_INSERT) ? front_dec : ring_add(r_front, r_count);
        scan_issue = (r_scan_idx < r_count);
        rd_en_a    = i_cmd.read_fb || (i_cmd.scan_step && scan_issue);
        rd_addr_a  = i_cmd.scan_step ? ring_add(r_front, r_scan_idx) : r_front;
        back_addr  = empty ? r_front : ring_add(r_front, r_count - CNT_W'(1));
        last_idx   = IDX_W'(r_count - CNT_W'(1));
        hit        = r_cmp_vld && (r_rd_a == r_value);
        out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (rd_en_a) begin
            r_rd_a <= mem[rd_addr_a];
        end
        if (i_cmd.read_fb) begin
            r_rd_b <= mem[back_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_mode)
                OP_INSERT: begin
                    if (!full) begin
                        r_front <= front_dec;
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                OP_APPEND: begin
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                OP_DROP: begin
                    if (!empty) begin
                        r_front <= ring_add(r_front, CNT_W'(1));
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                OP_SEARCH: begin
                    r_count <= r_count;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= t_lqs_op'(i_mode);
            r_value  <= VALUE_BITS'($unsigned(i_value));
            r_status <= STAT_DONE;
            r_found  <= 1'b0;
            r_pos    <= '0;
        end else if (i_cmd.exec) begin
            if ((r_mode == OP_INSERT || r_mode == OP_APPEND) && full) begin
                r_status <= STAT_FULL;
            end else if (r_mode == OP_DROP && empty) begin
                r_status <= STAT_EMPTY;
            end
        end else if (i_cmd.scan_step && hit) begin
            r_found <= 1'b1;
            r_pos   <= r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld  <= 1'b0;
            r_scan_idx <= '0;
        end else if (i_cmd.scan_start) begin
            r_cmp_vld  <= 1'b0;
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_cmp_vld <= scan_issue;
            if (scan_issue) begin
                r_cmp_idx  <= IDX_W'(r_scan_idx);
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_pos    <= POS_BITS'(r_pos);
            r_out_count  <= COUNT_BITS'(r_count);
            r_out_front  <= empty ? '0 : FIELD_BITS'(r_rd_a);
            r_out_back   <= empty ? '0 : FIELD_BITS'(r_rd_b);
        end
    end

    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.scan_end = hit || (r_cmp_vld ? (r_cmp_idx == last_idx) : !scan_issue);
        o_stat.out_free = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_position    = r_out_pos;
    assign o_count       = r_out_count;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

import lqs_pkg::*;

typedef struct {
    logic [STAT_BITS-1:0]         status;
    logic                         found;
    logic [POS_BITS-1:0]          position;
    logic [COUNT_BITS-1:0]        count;
    logic signed [FIELD_BITS-1:0] front_val;
    logic signed [FIELD_BITS-1:0] back_val;
} list_result_t;

class list_scoreboard;
    logic signed [FIELD_BITS-1:0] slot_val[DEPTH];
    int front_idx = 0;
    int held_num = 0;
    list_result_t pending_results[$];
    int mismatches = 0;
    int items_in = 0;
    int results_checked = 0;
    int searches = 0;
    int hits = 0;
    int full_refusals = 0;
    int empty_refusals = 0;

    function int slot_of(int k);
        return (front_idx + k) % DEPTH;
    endfunction

    function logic signed [FIELD_BITS-1:0] held_at(int k);
        return slot_val[slot_of(k)];
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction

    // Applies one list operation to the shadow list and queues the result it must give.
    function void note_item(t_lqs_op op, logic signed [FIELD_BITS-1:0] val);
        list_result_t r;
        r.status    = STAT_DONE;
        r.found     = 1'b0;
        r.position  = '0;
        r.front_val = '0;
        r.back_val  = '0;
        items_in++;
        case (op)
            OP_INSERT, OP_APPEND: begin
                if (held_num >= DEPTH) begin
                    r.status = STAT_FULL;
                    full_refusals++;
                end else if (op == OP_INSERT) begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    slot_val[front_idx] = val;
                    held_num++;
                end else begin
                    slot_val[slot_of(held_num)] = val;
                    held_num++;
                end
            end
            OP_DROP: begin
                if (held_num == 0) begin
                    r.status = STAT_EMPTY;
                    empty_refusals++;
                end else begin
                    front_idx = slot_of(1);
                    held_num--;
                end
            end
            default: begin
                searches++;
                for (int i = 0; i < held_num; i++) begin
                    if (slot_val[slot_of(i)] == val) begin
                        r.found    = 1'b1;
                        r.position = POS_BITS'(i);
                        hits++;
                        break;
                    end
                end
            end
        endcase
        r.count = COUNT_BITS'(held_num);
        if (held_num > 0) begin
            r.front_val = slot_val[front_idx];
            r.back_val  = slot_val[slot_of(held_num - 1)];
        end
        pending_results.push_back(r);
    endfunction

    function void check_item(list_result_t got);
        list_result_t exp;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH: result arrived with nothing expected (status=%0d count=%0d)",
                         got.status, got.count);
            end
            return;
        end
        exp = pending_results.pop_front();
        results_checked++;
        if (got.status !== exp.status || got.found !== exp.found ||
            got.position !== exp.position || got.count !== exp.count ||
            got.front_val !== exp.front_val || got.back_val !== exp.back_val) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH on result %0d: expected st=%0d fnd=%0d pos=%0d cnt=%0d f=%0d b=%0d",
                         results_checked, exp.status, exp.found, exp.position, exp.count,
                         exp.front_val, exp.back_val);
                $display("    got st=%0d fnd=%0d pos=%0d cnt=%0d f=%0d b=%0d",
                         got.status, got.found, got.position, got.count,
                         got.front_val, got.back_val);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 256;
    localparam int LONG_HOLD = 400;
    localparam int BIAS_FILL = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [MODE_BITS-1:0]         i_mode;
    logic signed [FIELD_BITS-1:0] i_value;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [STAT_BITS-1:0]         o_status;
    logic                         o_found;
    logic [POS_BITS-1:0]          o_position;
    logic [COUNT_BITS-1:0]        o_count;
    logic signed [FIELD_BITS-1:0] o_front_value;
    logic signed [FIELD_BITS-1:0] o_back_value;

    list_scoreboard sb;
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int idle_cycles;

    list_queue_with_search DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_count       (o_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    task automatic send_item(t_lqs_op op, logic signed [FIELD_BITS-1:0] val);
        i_in_valid <= 1'b1;
        i_mode     <= op;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_item(op, val);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(24, 1)) @(posedge i_clk);
        end
    endtask

    function automatic t_lqs_op pick_op(int bias);
        int r;
        r = $urandom_range(99);
        case (bias)
            BIAS_FILL: begin
                if (r < 30) return OP_INSERT;
                if (r < 60) return OP_APPEND;
                if (r < 75) return OP_DROP;
            end
            BIAS_DRAIN: begin
                if (r < 12) return OP_INSERT;
                if (r < 24) return OP_APPEND;
                if (r < 70) return OP_DROP;
            end
            default: begin
                if (r < 22) return OP_INSERT;
                if (r < 44) return OP_APPEND;
                if (r < 66) return OP_DROP;
            end
        endcase
        return OP_SEARCH;
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] pick_value(bit for_search);
        int r;
        r = $urandom_range(99);
        if (sb.held_num > 0 && r < (for_search ? 55 : 25)) begin
            return sb.held_at($urandom_range(sb.held_num - 1));
        end
        if (r < 70) begin
            case ($urandom_range(7))
                0: return 32'sd0;
                1: return 32'sd1;
                2: return -32'sd1;
                3: return 32'sh7fffffff;
                4: return 32'sh80000000;
                5: return 32'sd42;
                6: return -32'sd42;
                default: return 32'sh55555555;
            endcase
        end
        return $urandom;
    endfunction

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_item('{o_status, o_found, o_position, o_count,
                                o_front_value, o_back_value});
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                         idle_cycles, sb.outstanding());
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int bias;
        t_lqs_op op;
        sb = new;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = OP_INSERT;
        i_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_DROP, 32'sd7);
        send_item(OP_INSERT, 32'sh7fffffff);
        send_item(OP_INSERT, 32'sh80000000);
        send_item(OP_APPEND, 32'sd0);
        send_item(OP_APPEND, -32'sd1);
        send_item(OP_SEARCH, 32'sh80000000);
        send_item(OP_SEARCH, -32'sd1);
        send_item(OP_SEARCH, 32'sd12345);
        send_item(OP_APPEND, 32'sh7fffffff);
        send_item(OP_SEARCH, 32'sh7fffffff);
        send_item(OP_DROP, 32'sd0);
        send_item(OP_INSERT, 32'sh5a5a5a5a);
        for (int k = 1; k <= 11; k++) begin
            send_item(OP_APPEND, k * 32'sh11111111);
        end
        send_item(OP_INSERT, 32'sd99);
        send_item(OP_APPEND, 32'sd99);
        send_item(OP_SEARCH, 32'shbbbbbbbb);

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = (ph == 1) ? 45 : (ph == 3) ? 13 : 0;
            recv_stall_pct  = (ph == 2) ? 45 : (ph == 3) ? 13 : 0;
            bias = BIAS_MIXED;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 64) begin
                    hold_request = LONG_HOLD;
                end
                if (n % 32 == 0) begin
                    bias = $urandom_range(BIAS_MIXED);
                end
                op = pick_op(bias);
                send_item(op, pick_value(op == OP_SEARCH));
            end
        end
        i_in_valid <= 1'b0;

        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        $display("Ran %0d items and checked %0d results: %0d searches (%0d hits), %0d full and %0d empty refusals.",
                 sb.items_in, sb.results_checked, sb.searches, sb.hits,
                 sb.full_refusals, sb.empty_refusals);
        $display("Idling covered none, sender only, receiver only and both, plus one %0d-cycle output hold.",
                 LONG_HOLD);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
